FILE: src/srgb_contrast_ratio_assert.svh
// Assertion macros for the block's RTL.
`ifndef SRGB_CONTRAST_RATIO_ASSERT_SVH
`define SRGB_CONTRAST_RATIO_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante.
`define SCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/scr_pkg.sv
package scr_pkg;

    // Channel code width and linear-light format
    parameter int CHANNEL_BITS_DEF = 8;
    parameter int LIN_FRAC         = 24;
    parameter int LIN_W            = LIN_FRAC + 1;
    parameter int BIG_W            = 448;

    // Luminance weights, scaled by WEIGHT_TOTAL
    parameter int WEIGHT_R     = 2126;
    parameter int WEIGHT_G     = 7152;
    parameter int WEIGHT_B     = 722;
    parameter int WEIGHT_TOTAL = 10000;

    // Luminance datapath widths
    parameter int LUM_W       = 16;
    parameter int LUM_MAX     = 65535;
    parameter int SUM_W       = 38;
    parameter int SCALED_W    = SUM_W + LUM_W;
    parameter int Q_W         = 30;
    parameter int RECIP_SHIFT = 30;
    parameter int RECIP       = (2 ** RECIP_SHIFT) / WEIGHT_TOTAL;
    parameter int RECIP_W     = 17;
    parameter int QPROD_W     = Q_W + RECIP_W;
    parameter logic [SCALED_W-1:0] LUM_ROUND = SCALED_W'(WEIGHT_TOTAL / 2) << LIN_FRAC;

    // Ratio datapath widths
    parameter int RATIO_W    = 13;
    parameter int RATIO_FRAC = 8;
    parameter int LUM_SCALE  = 20;
    parameter int NUM_W      = 21;
    parameter int REM_W      = NUM_W + RATIO_FRAC;
    parameter int CMP_W      = NUM_W + RATIO_W;
    parameter int DIV_STEPS  = RATIO_W;
    parameter logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(256);
    parameter logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(5376);

    // Pipeline depth
    parameter int LANE_STAGES  = 7;
    parameter int MERGE_STAGES = DIV_STEPS + 1;
    parameter int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

    typedef struct packed {
        logic [LUM_W-1:0]   first_luminance;
        logic [LUM_W-1:0]   second_luminance;
        logic [RATIO_W-1:0] ratio;
        logic               first_is_lighter;
    } t_result;

    // Linear-light value of one sRGB code, Q1.24, rounded down.
    // Both segments find the largest y that satisfies the bound bit by bit.
    function automatic logic [LIN_W-1:0] lin_value(input int unsigned code,
                                                   input int unsigned max_code);
        logic [BIG_W-1:0] den12;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        logic [LIN_W-1:0] y;
        logic [LIN_W-1:0] cand;
        logic [63:0]      lin_num;
        logic [63:0]      lin_den;
        int unsigned      pw_num;
        y     = '0;
        den12 = BIG_W'(1);
        rhs   = BIG_W'(1);
        if (64'(code) * 64'd100000 <= 64'd4045 * 64'(max_code)) begin
            lin_num = (64'(code) * 64'd100) << LIN_FRAC;
            lin_den = 64'd1292 * 64'(max_code);
            for (int b = LIN_W - 1; b >= 0; b--) begin
                cand = y | (LIN_W'(1) << b);
                if (64'(cand) * lin_den <= lin_num) begin
                    y = cand;
                end
            end
        end else begin
            pw_num = 1000 * code + 55 * max_code;
            for (int k = 0; k < 12; k++) begin
                den12 = den12 * BIG_W'(1055 * max_code);
                rhs   = rhs * BIG_W'(pw_num);
            end
            rhs = rhs << (5 * LIN_FRAC);
            for (int b = LIN_W - 1; b >= 0; b--) begin
                cand = y | (LIN_W'(1) << b);
                lhs  = den12;
                for (int k = 0; k < 5; k++) begin
                    lhs = lhs * BIG_W'(cand);
                end
                if (lhs <= rhs) begin
                    y = cand;
                end
            end
        end
        return y;
    endfunction

endpackage

FILE: src/scr_in_if.sv
interface scr_in_if
    import scr_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] first_red;
    logic [CHANNEL_BITS-1:0] first_green;
    logic [CHANNEL_BITS-1:0] first_blue;
    logic [CHANNEL_BITS-1:0] second_red;
    logic [CHANNEL_BITS-1:0] second_green;
    logic [CHANNEL_BITS-1:0] second_blue;

    modport source (
        output valid, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
        input  ready
    );

    modport sink (
        input  valid, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
        output ready
    );
endinterface

FILE: src/scr_out_if.sv
interface scr_out_if
    import scr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LUM_W-1:0]   first_luminance;
    logic [LUM_W-1:0]   second_luminance;
    logic [RATIO_W-1:0] ratio;
    logic               first_is_lighter;

    modport source (
        output valid, first_luminance, second_luminance, ratio, first_is_lighter,
        input  ready
    );

    modport sink (
        input  valid, first_luminance, second_luminance, ratio, first_is_lighter,
        output ready
    );
endinterface

FILE: src/scr_lane.sv
module scr_lane
    import scr_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic [LANE_STAGES-1:0]  i_en,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic [LUM_W-1:0]        o_luminance
);

    localparam int ROM_DEPTH          = 2 ** CHANNEL_BITS;
    localparam int unsigned MAX_CODE = (2 ** CHANNEL_BITS) - 1;

    typedef logic [ROM_DEPTH-1:0][LIN_W-1:0] t_lin_rom;

    function automatic t_lin_rom build_rom();
        t_lin_rom rom;
        for (int c = 0; c < ROM_DEPTH; c++) begin
            rom[c] = lin_value(c, MAX_CODE);
        end
        return rom;
    endfunction

    localparam t_lin_rom LIN_ROM = build_rom();

    logic [LIN_W-1:0]    r_lin_r, r_lin_g, r_lin_b;
    logic [SUM_W-1:0]    r_prod_r, r_prod_g, r_prod_b;
    logic [SUM_W-1:0]    r_sum;
    logic [SCALED_W-1:0] n_scaled;
    logic [Q_W-1:0]      r_q3, r_q4, r_q5;
    logic [QPROD_W-1:0]  r_qprod;
    logic [LUM_W-1:0]    r_est;
    logic [Q_W-1:0]      n_rem;
    logic [LUM_W-1:0]    n_lum;
    logic [LUM_W-1:0]    r_lum;

    // Linearise each channel through the transfer-curve table
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lin_r <= LIN_ROM[i_red];
            r_lin_g <= LIN_ROM[i_green];
            r_lin_b <= LIN_ROM[i_blue];
        end
    end

    // Weight each channel
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod_r <= SUM_W'(r_lin_r) * SUM_W'(WEIGHT_R);
            r_prod_g <= SUM_W'(r_lin_g) * SUM_W'(WEIGHT_G);
            r_prod_b <= SUM_W'(r_lin_b) * SUM_W'(WEIGHT_B);
        end
    end

    // Sum the weighted channels
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sum <= r_prod_r + r_prod_g + r_prod_b;
        end
    end

    // Scale to full range with half a weight unit for rounding, drop the Q0.24 fraction
    assign n_scaled = SCALED_W'(r_sum) * SCALED_W'(LUM_MAX) + LUM_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_q3 <= Q_W'(n_scaled >> LIN_FRAC);
        end
    end

    // Divide by the weight total: reciprocal product first
    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_qprod <= QPROD_W'(r_q3) * QPROD_W'(RECIP);
            r_q4    <= r_q3;
        end
    end

    // Estimate is the true quotient or one below it
    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_est <= LUM_W'(r_qprod >> RECIP_SHIFT);
            r_q5  <= r_q4;
        end
    end

    // Correct the estimate by one compare on the remainder
    assign n_rem = r_q5 - Q_W'(r_est) * Q_W'(WEIGHT_TOTAL);
    assign n_lum = r_est + LUM_W'(n_rem >= Q_W'(WEIGHT_TOTAL));

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_lum <= n_lum;
        end
    end

    assign o_luminance = r_lum;

endmodule

FILE: src/scr_merge.sv
module scr_merge
    import scr_pkg::*;
(
    input  logic                    i_clk,
    input  logic [MERGE_STAGES-1:0] i_en,
    input  logic [LUM_W-1:0]        i_first_lum,
    input  logic [LUM_W-1:0]        i_second_lum,
    output t_result                 o_result
);

    logic [REM_W-1:0]   r_rem  [DIV_STEPS+1];
    logic [NUM_W-1:0]   r_den  [DIV_STEPS+1];
    logic [RATIO_W-1:0] r_quo  [DIV_STEPS+1];
    logic [LUM_W-1:0]   r_l1   [DIV_STEPS+1];
    logic [LUM_W-1:0]   r_l2   [DIV_STEPS+1];
    logic               r_flag [DIV_STEPS+1];

    logic               n_lighter;
    logic [LUM_W-1:0]   n_high;
    logic [LUM_W-1:0]   n_low;
    logic [NUM_W-1:0]   n_num;
    logic [NUM_W-1:0]   n_den;

    // Order the two luminances and form the offset numerator and denominator
    always_comb begin
        n_lighter = i_first_lum > i_second_lum;
        n_high    = n_lighter ? i_first_lum : i_second_lum;
        n_low     = n_lighter ? i_second_lum : i_first_lum;
        n_num     = NUM_W'(n_high) * NUM_W'(LUM_SCALE) + NUM_W'(LUM_MAX);
        n_den     = NUM_W'(n_low) * NUM_W'(LUM_SCALE) + NUM_W'(LUM_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]  <= {n_num, RATIO_FRAC'(0)};
            r_den[0]  <= n_den;
            r_quo[0]  <= '0;
            r_l1[0]   <= i_first_lum;
            r_l2[0]   <= i_second_lum;
            r_flag[0] <= n_lighter;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        localparam int QBIT = DIV_STEPS - j;

        logic [CMP_W-1:0] n_trial;
        logic [CMP_W-1:0] n_rem_ext;
        logic             n_take;
        logic [REM_W-1:0] n_rem;

        always_comb begin
            n_trial   = CMP_W'(r_den[j-1]) << QBIT;
            n_rem_ext = CMP_W'(r_rem[j-1]);
            n_take    = n_rem_ext >= n_trial;
            n_rem     = n_take ? REM_W'(n_rem_ext - n_trial) : r_rem[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j]  <= n_rem;
                r_den[j]  <= r_den[j-1];
                r_quo[j]  <= r_quo[j-1] | (RATIO_W'(n_take) << QBIT);
                r_l1[j]   <= r_l1[j-1];
                r_l2[j]   <= r_l2[j-1];
                r_flag[j] <= r_flag[j-1];
            end
        end
    end

    assign o_result.first_luminance  = r_l1[DIV_STEPS];
    assign o_result.second_luminance = r_l2[DIV_STEPS];
    assign o_result.ratio            = r_quo[DIV_STEPS];
    assign o_result.first_is_lighter = r_flag[DIV_STEPS];

endmodule

FILE: src/srgb_contrast_ratio.sv
// Channel | Direction | Transaction carries
// i_in    | sink      | two colours, red/green/blue codes each
// o_out   | source    | both luminances, contrast ratio, first-is-lighter flag
//
// One transaction per cycle sustained while the output is ready; each result passes
// through 7 stages in a luminance lane, then 14 in the ratio divider.
// The divider produces one quotient bit per stage, which sets the depth.
// Reset clears the stage valid bits only; the transfer-curve table is constant.
// A stage advances when the next one is empty or advancing, so a stalled
// output only holds back stages that are full.
`include "srgb_contrast_ratio_assert.svh"

module srgb_contrast_ratio
    import scr_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scr_in_if.sink         i_in,
    scr_out_if.source      o_out
);

    localparam logic [NUM_STAGES-1:0] ALL_ONES = '1;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] feed;
    logic                  in_acc;
    logic [LUM_W-1:0]      first_lum;
    logic [LUM_W-1:0]      second_lum;
    t_result               result;

    // Stage k may load when any stage from k onward is empty or the output drains
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            en[k] = o_out.ready || ((r_valid | (ALL_ONES >> (NUM_STAGES - k))) != ALL_ONES);
        end
    end

    assign i_in.ready = i_rst_n && en[0];
    assign in_acc     = i_in.valid && i_in.ready;

    // Advance the valid bits alongside the payload
    assign feed    = {r_valid[NUM_STAGES-2:0], in_acc};
    assign n_valid = (en & feed) | (~en & r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    scr_lane #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_lane_first (
        .i_clk       (i_clk),
        .i_en        (en[LANE_STAGES-1:0]),
        .i_red       (i_in.first_red),
        .i_green     (i_in.first_green),
        .i_blue      (i_in.first_blue),
        .o_luminance (first_lum)
    );

    scr_lane #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_lane_second (
        .i_clk       (i_clk),
        .i_en        (en[LANE_STAGES-1:0]),
        .i_red       (i_in.second_red),
        .i_green     (i_in.second_green),
        .i_blue      (i_in.second_blue),
        .o_luminance (second_lum)
    );

    scr_merge u_merge (
        .i_clk        (i_clk),
        .i_en         (en[NUM_STAGES-1:LANE_STAGES]),
        .i_first_lum  (first_lum),
        .i_second_lum (second_lum),
        .o_result     (result)
    );

    assign o_out.valid            = r_valid[NUM_STAGES-1];
    assign o_out.first_luminance  = result.first_luminance;
    assign o_out.second_luminance = result.second_luminance;
    assign o_out.ratio            = result.ratio;
    assign o_out.first_is_lighter = result.first_is_lighter;

    `SCR_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in.valid && i_in.ready, r_valid[0], "accepted transaction did not enter the first stage")
    `SCR_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !(&r_valid), i_in.ready, "input stalled with an empty stage in the pipeline")
    `SCR_ASSERT_IMPL(a_ratio_range, i_clk, i_rst_n, o_out.valid, (o_out.ratio >= RATIO_ONE) && (o_out.ratio <= RATIO_MAX), "ratio outside 1.0 to 21.0")
    `SCR_ASSERT_IMPL(a_flag_match, i_clk, i_rst_n, o_out.valid, o_out.first_is_lighter == (o_out.first_luminance > o_out.second_luminance), "lighter flag disagrees with luminances")
    `SCR_ASSERT_IMPL(a_equal_unity, i_clk, i_rst_n, o_out.valid && (o_out.first_luminance == o_out.second_luminance), o_out.ratio == RATIO_ONE, "equal luminances without unity ratio")

endmodule
